FILE: hw/rtl/ngpd_pkg.sv
// shared types and constants of the nearest-grid-point deposit block
package ngpd_pkg;

  localparam int unsigned GRID_SIZE_DEF = 32;
  localparam int unsigned STORE_DEPTH   = 32768;
  localparam int unsigned ADDR_W        = $clog2(STORE_DEPTH);
  localparam int unsigned ADDR_W1       = ADDR_W + 1;
  localparam int unsigned SUM_W         = 48;

  typedef enum logic [1:0] {
    KIND_DEPOSIT = 2'd0,
    KIND_READ    = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STS_DEPOSITED = 3'd0,
    STS_OUTSIDE   = 3'd1,
    STS_RANGE     = 3'd2,
    STS_READ      = 3'd3,
    STS_CLEARED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_CELLS_PER_LENGTH = 2'd0,
    REG_CLIP_ENABLE      = 2'd1,
    REG_REGION_LOW       = 2'd2,
    REG_REGION_HIGH      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    kind_t              kind;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        mass;
    logic [ADDR_W-1:0]  cell_addr;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [ADDR_W-1:0]       cell_used;
    logic [SUM_W-1:0]        mass_sum;
    logic signed [SUM_W-1:0] vx_sum;
    logic signed [SUM_W-1:0] vy_sum;
    logic signed [SUM_W-1:0] vz_sum;
  } out_item_t;

  // one stored cell: all four sums side by side in one memory word
  typedef struct packed {
    logic [SUM_W-1:0]        mass;
    logic signed [SUM_W-1:0] vx;
    logic signed [SUM_W-1:0] vy;
    logic signed [SUM_W-1:0] vz;
  } cell_t;

  typedef struct packed {
    logic [31:0] cells_per_length;
    logic        clip_enable;
    logic [31:0] region_low;
    logic [31:0] region_high;
  } cfg_t;

  // what the address stage decided for the current transaction
  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] cell_idx;
  } plan_t;

endpackage

FILE: hw/rtl/ngpd_addr.sv
// position to cell index mapping: clip, scale, floor and range check
module ngpd_addr import ngpd_pkg::*; #(
  parameter int unsigned GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic     clk,
  input  logic     map_en,
  input  logic     idx_en,
  input  in_item_t item,
  input  cfg_t     cfg,
  output plan_t    plan
);

  localparam int unsigned CW     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int unsigned IW     = 3 * CW;
  localparam int unsigned IW1    = IW + 1;
  localparam int unsigned CELLS  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int unsigned USABLE = (CELLS < STORE_DEPTH) ? CELLS : STORE_DEPTH;

  logic [2:0][31:0] pos;
  logic [2:0][31:0] pos_rel;
  logic [2:0][63:0] prod;
  logic [2:0]       outside_ax;
  logic [2:0][31:0] coord_r;
  logic             outside_r;
  logic [2:0]       axis_ok;
  logic [IW-1:0]    idx;
  logic             idx_ok;
  logic             addr_ok;
  plan_t            plan_r;
  plan_t            plan_nxt;

  assign pos = {item.pos_z, item.pos_y, item.pos_x};

  // stage one: region test, origin shift and one multiplier per axis
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      outside_ax[d] = cfg.clip_enable &&
                      ((pos[d] <= cfg.region_low) || (pos[d] >= cfg.region_high));
      pos_rel[d]    = cfg.clip_enable ? (pos[d] - cfg.region_low) : pos[d];
      prod[d]       = 64'(pos_rel[d]) * 64'(cfg.cells_per_length);
    end
  end

  always_ff @(posedge clk) begin
    if (map_en) begin
      for (int d = 0; d < 3; d++) begin
        coord_r[d] <= prod[d][63:32];
      end
      outside_r <= |outside_ax;
    end
  end

  // stage two: per-axis bound, flat index and store bound
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      axis_ok[d] = coord_r[d] < 32'(GRID_SIZE);
    end
    idx = (IW'(coord_r[0][CW-1:0]) * IW'(GRID_SIZE) + IW'(coord_r[1][CW-1:0]))
          * IW'(GRID_SIZE) + IW'(coord_r[2][CW-1:0]);
    idx_ok  = {1'b0, idx} < IW1'(USABLE);
    addr_ok = {1'b0, item.cell_addr} < ADDR_W1'(USABLE);
  end

  always_comb begin
    plan_nxt = '{status: STS_RANGE, cell_idx: '0};
    case (item.kind)
      KIND_DEPOSIT: begin
        if (outside_r) begin
          plan_nxt.status = STS_OUTSIDE;
        end else if ((&axis_ok) && idx_ok) begin
          plan_nxt.status   = STS_DEPOSITED;
          plan_nxt.cell_idx = ADDR_W'(idx);
        end
      end
      KIND_CLEAR: begin
        if (addr_ok) begin
          plan_nxt.status   = STS_CLEARED;
          plan_nxt.cell_idx = item.cell_addr;
        end
      end
      default: begin
        // unused kind code reads like a read
        if (addr_ok) begin
          plan_nxt.status   = STS_READ;
          plan_nxt.cell_idx = item.cell_addr;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (idx_en) begin
      plan_r <= plan_nxt;
    end
  end

  assign plan = plan_r;

endmodule

FILE: hw/rtl/ngpd_accum.sv
// saturating accumulation of one particle into one cell
module ngpd_accum import ngpd_pkg::*; (
  input  cell_t    cur,
  input  in_item_t item,
  output cell_t    sum
);

  function automatic logic [SUM_W-1:0] sat_mass(input logic [SUM_W-1:0] a,
                                                input logic [31:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W - 31){1'b0}}, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_vel(input logic [SUM_W-1:0] a,
                                               input logic [31:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W - 31){b[31]}}, b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      // overflow: clamp toward the sign of the true sum
      return s[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

  always_comb begin
    sum.mass = sat_mass(cur.mass, item.mass);
    sum.vx   = sat_vel(cur.vx, item.vel_x);
    sum.vy   = sat_vel(cur.vy, item.vel_y);
    sum.vz   = sat_vel(cur.vz, item.vel_z);
  end

endmodule

FILE: hw/rtl/ngpd_store.sv
// cell sum memory with registered read port and clearing pass after reset
module ngpd_store import ngpd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output cell_t             rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  cell_t             wr_data,
  output logic              clearing
);

  cell_t             mem [STORE_DEPTH];
  cell_t             rd_data_r;
  logic              clr_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !wr_en)
    else $error("cell write during clearing pass");

  a_clear_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_r) |-> $past(clr_cnt_r) == ADDR_W'(STORE_DEPTH - 1))
    else $error("clearing pass ended early");

endmodule

FILE: hw/rtl/ngp_particle_deposit.sv
// top level of the nearest-grid-point particle deposit block
// after start is accepted, a result strobes from a register loaded in the write back step
// each transaction passes the map, index, read and write steps in order;
//   the next transaction enters during write back of the previous one
// reset: synchronous active-low; registers return to defaults, then a clearing pass over
//   every cell zeroes the cell memory while busy stays high; the receiver cannot stall
module ngp_particle_deposit import ngpd_pkg::*; #(
  parameter int unsigned GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // transaction input
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  // result output, one cycle per result
  output logic        out_strobe,
  output out_item_t   out_item,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // one-hot sequencer: map (multiply), index, memory read, write back
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAP   = 5'b00010,
    S_IDX   = 5'b00100,
    S_READ  = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t    state_r;
  state_t    state_nxt;
  in_item_t  item_r;
  cfg_t      cfg_r;
  plan_t     plan;
  cell_t     rd_cell;
  cell_t     acc_cell;
  cell_t     wr_cell;
  logic      wr_en;
  logic      clearing;
  logic      accept;
  logic      out_strobe_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  // new transaction may enter during write back of the previous one
  assign busy   = clearing || !((state_r == S_IDLE) || (state_r == S_WRITE));
  assign accept = start && !busy;

  // register file: ready only while idle, so no transaction in flight sees a change
  assign cfg_ready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cells_per_length <= 32'd65536;
      cfg_r.clip_enable      <= 1'b0;
      cfg_r.region_low       <= '0;
      cfg_r.region_high      <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELLS_PER_LENGTH: cfg_r.cells_per_length <= cfg_data;
        REG_CLIP_ENABLE:      cfg_r.clip_enable      <= cfg_data[0];
        REG_REGION_LOW:       cfg_r.region_low       <= cfg_data;
        REG_REGION_HIGH:      cfg_r.region_high      <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the transaction for the whole pass
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MAP;
      S_MAP:   state_nxt = S_IDX;
      S_IDX:   state_nxt = S_READ;
      S_READ:  state_nxt = S_WRITE;
      S_WRITE: state_nxt = accept ? S_MAP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  ngpd_addr #(
    .GRID_SIZE (GRID_SIZE)
  ) u_addr (
    .clk    (clk),
    .map_en (state_r == S_MAP),
    .idx_en (state_r == S_IDX),
    .item   (item_r),
    .cfg    (cfg_r),
    .plan   (plan)
  );

  // only one transaction touches the memory at a time, so the read in
  // S_READ always sees the previous write back
  ngpd_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (state_r == S_READ),
    .rd_addr  (plan.cell_idx),
    .rd_data  (rd_cell),
    .wr_en    (wr_en),
    .wr_addr  (plan.cell_idx),
    .wr_data  (wr_cell),
    .clearing (clearing)
  );

  ngpd_accum u_accum (
    .cur  (rd_cell),
    .item (item_r),
    .sum  (acc_cell)
  );

  // write back and result selection
  always_comb begin
    wr_en        = 1'b0;
    wr_cell      = '0;
    out_item_nxt = '0;
    out_item_nxt.status = plan.status;
    case (plan.status)
      STS_DEPOSITED: begin
        wr_en   = state_r == S_WRITE;
        wr_cell = acc_cell;
        out_item_nxt.cell_used = plan.cell_idx;
        out_item_nxt.mass_sum  = acc_cell.mass;
        out_item_nxt.vx_sum    = acc_cell.vx;
        out_item_nxt.vy_sum    = acc_cell.vy;
        out_item_nxt.vz_sum    = acc_cell.vz;
      end
      STS_READ: begin
        out_item_nxt.cell_used = plan.cell_idx;
        out_item_nxt.mass_sum  = rd_cell.mass;
        out_item_nxt.vx_sum    = rd_cell.vx;
        out_item_nxt.vy_sum    = rd_cell.vy;
        out_item_nxt.vz_sum    = rd_cell.vz;
      end
      STS_CLEARED: begin
        wr_en = state_r == S_WRITE;
        out_item_nxt.cell_used = plan.cell_idx;
      end
      default: ;  // dropped: all fields but status stay zero
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= state_r == S_WRITE;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy low right after an accepted transaction");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_strobe)
    else $error("result strobe not 4 cycles after accept");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ((out_item.status == STS_OUTSIDE) || (out_item.status == STS_RANGE))
    |-> (out_item.cell_used == '0) && (out_item.mass_sum == '0) &&
        (out_item.vx_sum == '0) && (out_item.vy_sum == '0) && (out_item.vz_sum == '0))
    else $error("dropped transaction carries nonzero fields");

endmodule
